### hw/rtl/hex_frame_receiver_with_sum_core_assert.svh
// Assertion macros for the checker of the hex frame receiver.
`ifndef HEX_FRAME_RECEIVER_WITH_SUM_CORE_ASSERT_SVH
`define HEX_FRAME_RECEIVER_WITH_SUM_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define HFR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hfr assertion failed");

// Next-cycle implication, sampled on clk, off during reset
`define HFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hfr assertion failed");

`endif

### hw/rtl/hfr_pkg.sv
// Shared types, constants and the hex digit decoder of the hex frame receiver.
package hfr_pkg;

  localparam int COUNT_W   = 6;
  localparam int BYTE_W    = 8;
  localparam int MAX_BYTES = 16;
  localparam int WORD_W    = 64;

  localparam logic [7:0] CHAR_NL = 8'h0A;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_LENGTH = 2'd1,
    ERR_DIGIT  = 2'd2,
    ERR_SUM    = 2'd3
  } err_code_t;

  // Character held in the input stage
  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
  } hfr_char_t;

  // One frame result
  typedef struct packed {
    logic              frame_valid;
    logic [1:0]        error_code;
    logic [WORD_W-1:0] data_low;
    logic [WORD_W-1:0] data_high;
  } hfr_result_t;

  // Returns {bad, value}; bad is set when c is not a hex digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b0, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

endpackage

### hw/rtl/hfr_if.sv
// Valid/ready channel interfaces for characters and frame results.
interface hfr_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

interface hfr_result_if;
  logic        valid;
  logic        ready;
  logic        frame_valid;
  logic [1:0]  error_code;
  logic [63:0] data_low;
  logic [63:0] data_high;

  modport source (output valid, output frame_valid, output error_code,
                  output data_low, output data_high, input ready);
  modport sink (input valid, input frame_valid, input error_code,
                input data_low, input data_high, output ready);
  modport monitor (input valid, input ready, input frame_valid, input error_code,
                   input data_low, input data_high);
endinterface

### hw/rtl/hfr_in_stage.sv
// Input register: takes one character request and holds it until it is processed.
module hfr_in_stage (
  input  logic             clk,
  input  logic             rst,
  hfr_char_if.sink         char_chan,
  input  logic             advance,
  output hfr_pkg::hfr_char_t s1
);
  import hfr_pkg::*;

  logic take;

  // Free when empty or when the held character moves on this cycle
  assign char_chan.ready = !s1.valid || advance;
  assign take            = char_chan.valid && char_chan.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (take) begin
      s1.valid <= 1'b1;
    end else if (advance) begin
      s1.valid <= 1'b0;
    end
    if (take) begin
      s1.ch <= char_chan.char_in;
    end
  end

endmodule

### hw/rtl/hfr_frame.sv
// Frame state: character count, decoded bytes, sums and the result on newline.
module hfr_frame #(
  parameter int FRAME_BYTES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_data,
  input  hfr_pkg::hfr_char_t   s1,
  input  logic                 go,
  output logic                 wants_result,
  output logic                 res_load,
  output hfr_pkg::hfr_result_t result
);
  import hfr_pkg::*;

  localparam logic [COUNT_W-1:0] DIGITS_DATA = COUNT_W'(2 * FRAME_BYTES);
  localparam logic [COUNT_W-1:0] COUNT_FULL  = COUNT_W'(2 * FRAME_BYTES + 2);
  localparam logic [COUNT_W-1:0] COUNT_SAT   = COUNT_W'(2 * FRAME_BYTES + 3);

  logic                              panel_enabled;
  logic [COUNT_W-1:0]                char_count;
  logic [FRAME_BYTES-1:0][BYTE_W-1:0] data_bytes;
  logic [3:0]                        high_nibble;
  logic                              digit_bad_pair;
  logic [BYTE_W-1:0]                 running_sum;
  logic [BYTE_W-1:0]                 received_sum;
  logic                              data_digit_bad;
  logic                              sum_digit_bad;

  logic                              is_nl;
  logic                              step;
  logic [4:0]                        dec;
  logic                              bad;
  logic [3:0]                        nib;
  logic                              pair_bad;
  logic [BYTE_W-1:0]                 byte_val;
  logic [2*WORD_W-1:0]               data_all;
  err_code_t                         code;

  assign is_nl        = (s1.ch == CHAR_NL);
  assign wants_result = panel_enabled && is_nl;
  assign step         = go && panel_enabled;
  assign res_load     = step && is_nl;

  // Digit decode and byte assembly for the current character
  assign dec      = hex_decode(s1.ch);
  assign bad      = dec[4];
  assign nib      = bad ? 4'd0 : dec[3:0];
  assign pair_bad = digit_bad_pair | bad;
  assign byte_val = pair_bad ? '0 : {high_nibble, nib};

  // Frame state update
  always_ff @(posedge clk) begin
    if (rst) begin
      panel_enabled  <= 1'b1;
      char_count     <= '0;
      data_bytes     <= '0;
      high_nibble    <= '0;
      digit_bad_pair <= 1'b0;
      running_sum    <= '0;
      received_sum   <= '0;
      data_digit_bad <= 1'b0;
      sum_digit_bad  <= 1'b0;
    end else begin
      if (cfg_we) begin
        panel_enabled <= cfg_data;
      end
      if (step) begin
        if (is_nl) begin
          char_count     <= '0;
          data_bytes     <= '0;
          high_nibble    <= '0;
          digit_bad_pair <= 1'b0;
          running_sum    <= '0;
          received_sum   <= '0;
          data_digit_bad <= 1'b0;
          sum_digit_bad  <= 1'b0;
        end else if (char_count < COUNT_SAT) begin
          char_count <= char_count + 1'b1;
          if (char_count < COUNT_FULL) begin
            if (!char_count[0]) begin
              high_nibble    <= nib;
              digit_bad_pair <= bad;
            end else if (char_count < DIGITS_DATA) begin
              for (int i = 0; i < FRAME_BYTES; i++) begin
                if (char_count[COUNT_W-1:1] == (COUNT_W-1)'(i)) begin
                  data_bytes[i] <= byte_val;
                end
              end
              running_sum <= running_sum + byte_val;
              if (pair_bad) begin
                data_digit_bad <= 1'b1;
              end
            end else begin
              received_sum <= byte_val;
              if (pair_bad) begin
                sum_digit_bad <= 1'b1;
              end
            end
          end
        end
      end
    end
  end

  // Result on newline, checks in priority order
  always_comb begin
    data_all = '0;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      data_all[i*BYTE_W +: BYTE_W] = data_bytes[i];
    end
    priority if (char_count != COUNT_FULL) begin
      code     = ERR_LENGTH;
      data_all = '0;
    end else if (data_digit_bad || sum_digit_bad) begin
      code = ERR_DIGIT;
    end else if (received_sum != running_sum) begin
      code = ERR_SUM;
    end else begin
      code = ERR_NONE;
    end
    result.frame_valid = (code == ERR_NONE);
    result.error_code  = code;
    result.data_low    = data_all[WORD_W-1:0];
    result.data_high   = data_all[2*WORD_W-1:WORD_W];
  end

endmodule

### hw/rtl/hfr_out_reg.sv
// Result register: holds one frame result until the consumer takes it.
module hfr_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  hfr_pkg::hfr_result_t result,
  output logic                 free,
  hfr_result_if.source         result_chan
);
  import hfr_pkg::*;

  logic        valid;
  hfr_result_t held;

  assign free = !valid || result_chan.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result_chan.ready) begin
      valid <= 1'b0;
    end
    if (load) begin
      held <= result;
    end
  end

  assign result_chan.valid       = valid;
  assign result_chan.frame_valid = held.frame_valid;
  assign result_chan.error_code  = held.error_code;
  assign result_chan.data_low    = held.data_low;
  assign result_chan.data_high   = held.data_high;

endmodule

### hw/rtl/hex_frame_receiver_with_sum_core.sv
// Top level of the hex frame receiver with additive checksum.
//
// char_chan takes one ASCII character per request. A frame is 2*FRAME_BYTES
// hex digits (most significant nibble first), two checksum digits and a
// newline. Each newline taken with panel_enabled set gives one request on
// result_chan: frame_valid, error_code (ok, wrong length, bad digit,
// checksum mismatch) and the bytes, first byte in data_low[7:0]. Other
// characters give no result. cfg_we/cfg_data write panel_enabled; while it
// is clear, characters are taken and dropped, and the frame state is kept.
// A newline is registered in the input register, its result in the result reg.
// Throughput: one character per cycle while no newline is stalled, set by the
// input register and the single-pass state update that follows it.
// Reset (rst, synchronous) empties both registers, clears the frame state
// and sets panel_enabled. When result_chan stalls, the result register holds,
// ordinary characters keep flowing, and a following newline waits in the
// input register, which then drops char_chan.ready.
module hex_frame_receiver_with_sum_core #(
  parameter int FRAME_BYTES = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_data,
  hfr_char_if.sink     char_chan,
  hfr_result_if.source result_chan
);
  import hfr_pkg::*;

  hfr_char_t   s1;
  hfr_result_t result;
  logic        wants_result;
  logic        res_load;
  logic        out_free;
  logic        go;

  // Held character moves on unless it needs the busy result register
  assign go = s1.valid && (!wants_result || out_free);

  hfr_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .char_chan (char_chan),
    .advance   (go),
    .s1        (s1)
  );

  hfr_frame #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_frame (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .s1           (s1),
    .go           (go),
    .wants_result (wants_result),
    .res_load     (res_load),
    .result       (result)
  );

  hfr_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (res_load),
    .result      (result),
    .free        (out_free),
    .result_chan (result_chan)
  );

endmodule

### hw/rtl/hfr_checker.sv
// Port-level checker for the hex frame receiver, bound to the top level.
`include "hex_frame_receiver_with_sum_core_assert.svh"

module hfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic        frame_valid,
  input logic [1:0]  error_code,
  input logic [63:0] data_low,
  input logic [63:0] data_high
);
  import hfr_pkg::*;

  logic stall;
  logic len_err;
  logic data_zero;

  assign stall     = valid && !ready;
  assign len_err   = valid && (error_code == ERR_LENGTH);
  assign data_zero = (data_low == '0) && (data_high == '0);

  // Valid flag agrees with the error code
  `HFR_ASSERT_NOW(a_valid_code, clk, rst, valid, frame_valid == (error_code == ERR_NONE))

  // A wrong-length frame reports no data
  `HFR_ASSERT_NOW(a_len_zero, clk, rst, len_err, data_zero)

  // A stalled result request stays up
  `HFR_ASSERT_NEXT(a_hold_valid, clk, rst, stall, valid)

  // A stalled result keeps its payload
  `HFR_ASSERT_NEXT(a_hold_data, clk, rst, stall, $stable({error_code, data_low, data_high}))

endmodule

bind hex_frame_receiver_with_sum_core hfr_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .valid       (result_chan.valid),
  .ready       (result_chan.ready),
  .frame_valid (result_chan.frame_valid),
  .error_code  (result_chan.error_code),
  .data_low    (result_chan.data_low),
  .data_high   (result_chan.data_high)
);
